// File: rtl/scp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_pkg: shared types and tables for the similarity pose chain
// Tag type for the shared multiplier, operation and error codes, operand
// tables for the quaternion product and rotation matrix, saturation helpers.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int QW   = 16;
    localparam int TW   = 32;
    localparam int MOPW = 33;
    localparam int PW   = 66;
    localparam int SUMW = 56;
    localparam int MW   = 20;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPOSE = 2'd1;
    localparam logic [1:0] OP_INVERT  = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_SAT  = 2'd1;
    localparam logic [1:0] ERR_ZERO = 2'd2;

    typedef enum logic [2:0] {K_QP, K_PP, K_ROT, K_TS, K_SS, K_TI} kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [3:0] idx;
    } tag_t;

    // component index: 0 x, 1 y, 2 z, 3 w
    localparam logic [1:0] QP_A [4]  = '{2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] QP_B [16] = '{2'd0, 2'd3, 2'd2, 2'd1,
                                         2'd1, 2'd2, 2'd3, 2'd0,
                                         2'd2, 2'd1, 2'd0, 2'd3,
                                         2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [15:0] QP_NEG = 16'hE428;

    // squares and cross products: xx yy zz ww xy xz yz wx wy wz
    localparam logic [1:0] PP_A [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                         2'd0, 2'd1, 2'd3, 2'd3, 2'd3};
    localparam logic [1:0] PP_B [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                         2'd2, 2'd2, 2'd0, 2'd1, 2'd2};

    localparam logic [1:0] ROT_ROW [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
                                           2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] ROT_COL [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
                                           2'd2, 2'd0, 2'd1, 2'd2};

    function automatic logic [16:0] sat_q(input logic signed [55:0] v);
        logic [16:0] r;
        if (v > 56'sd32767)
            r = {1'b1, 16'h7FFF};
        else if (v < -56'sd32768)
            r = {1'b1, 16'h8000};
        else
            r = {1'b0, v[15:0]};
        return r;
    endfunction

    function automatic logic [32:0] sat_t(input logic signed [55:0] v);
        logic [32:0] r;
        if (v > 56'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -56'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/scp_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_mul: shared signed multiplier
// Registered 33 x 33 product; the tag travels with it to steer the result.
// ----------------------------------------------------------------------------
module scp_mul
    import scp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic signed [MOPW-1:0] a,
    input  wire logic signed [MOPW-1:0] b,
    input  wire tag_t                   tag_in,
    output logic signed [PW-1:0]        prod,
    output tag_t                        tag
);

    logic signed [PW-1:0] prod_reg;
    tag_t                 tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
    assign tag  = tag_reg;

endmodule
`default_nettype wire

// File: rtl/scp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_div: serial reciprocal divider
// Restoring division of 2^48 by the divisor, one quotient bit a cycle,
// result saturated to 32 bits unsigned.
// ----------------------------------------------------------------------------
module scp_div
    import scp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quot,
    output logic             ovf
);

    localparam int QBITS = 49;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [31:0]       rem_reg;
    logic [QBITS-1:0]  quo_reg;
    logic [32:0]       rem_sh;
    logic              qbit;
    logic [32:0]       rem_diff;

    always_comb
    begin
        rem_sh   = {rem_reg, (cnt_reg == 6'(QBITS - 1))};
        qbit     = (rem_sh >= {1'b0, divisor});
        rem_diff = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(QBITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? rem_diff[31:0] : rem_sh[31:0];
            quo_reg <= {quo_reg[QBITS-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign ovf  = |quo_reg[QBITS-1:32];
    assign quot = ovf ? 32'hFFFF_FFFF : quo_reg[31:0];

endmodule
`default_nettype wire

// File: rtl/similarity_pose_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// similarity_pose_chain: accumulated 3D similarity transform
// Holds a quaternion, translation and scale; each request loads, composes on
// the right, inverts or reads it, and answers with the accumulator.
// ----------------------------------------------------------------------------
// Use:
//   Slave channel s_*: one request per transfer, operation in s_tuser.
//   Master channel m_*: one response per request, error code in m_tuser.
//   s_tready is high only while the sequencer is idle; one request is worked
//   on at a time through one shared 33 x 33 multiplier.
//   Steps per operation: load and read go straight to the response; compose
//   runs 16 quaternion products, 10 matrix products, 9 rotation products and
//   4 scale products; invert runs the serial reciprocal divider, then 3 + 10 + 9
//   products. Invert of a zero scale skips the divider and answers with error 2.
//   The response sits in an output register; a new request is taken while
//   it waits, but the next response holds until m_tready frees the register.
//   Reset: identity rotation, zero translation, unit scale, no response.
// ----------------------------------------------------------------------------
module similarity_pose_chain
    import scp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // in_qx, in_qy, in_qz, in_qw, in_tx, in_ty, in_tz, in_scale
    input  wire logic [191:0] s_tdata,
    // operation
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_qx, out_qy, out_qz, out_qw, out_tx, out_ty, out_tz, out_scale
    output logic [191:0]      m_tdata,
    // error
    output logic [1:0]        m_tuser
);

    typedef enum logic [3:0] {
        S_IDLE, S_QP, S_PP, S_MAT, S_ROT, S_TS, S_SS,
        S_DIVST, S_DIVW, S_TI, S_FIN, S_DONE
    } state_t;

    localparam logic [4:0] N_QP  = 5'd16;
    localparam logic [4:0] N_PP  = 5'd10;
    localparam logic [4:0] N_ROT = 5'd9;
    localparam logic [4:0] N_TS  = 5'd3;
    localparam logic [4:0] N_SS  = 5'd1;
    localparam logic [4:0] N_TI  = 5'd3;

    state_t                state_reg;
    logic [4:0]            cnt_reg;
    logic [1:0]            op_reg;
    logic                  err_reg;
    logic [1:0]            code_reg;
    logic signed [QW-1:0]  acc_q_reg [4];
    logic signed [TW-1:0]  acc_t_reg [3];
    logic [TW-1:0]         acc_s_reg;
    logic                  m_tvalid_reg;
    logic [191:0]          out_data_reg;
    logic [1:0]            out_user_reg;

    logic signed [QW-1:0]  bq_reg [4];
    logic [TW-1:0]         bs_reg;
    logic signed [QW-1:0]  rq_reg [4];
    logic signed [TW-1:0]  vv_reg [3];
    logic signed [TW-1:0]  pp_reg [10];
    logic signed [MW-1:0]  m_reg [9];
    logic signed [SUMW-1:0] sum_reg;
    logic signed [QW-1:0]  nq_reg [4];
    logic signed [TW-1:0]  rt_reg [3];
    logic signed [TW-1:0]  nt_reg [3];
    logic [TW-1:0]         ns_reg;
    logic [TW-1:0]         inv_reg;

    logic                  accept;
    logic signed [QW-1:0]  in_q [4];
    logic signed [TW-1:0]  in_t [3];
    logic [TW-1:0]         in_scale;

    logic [3:0]            iidx;
    logic signed [MOPW-1:0] op_a;
    logic signed [MOPW-1:0] op_b;
    tag_t                  issue;
    logic signed [PW-1:0]  prod;
    tag_t                  tag;

    logic                  div_start;
    logic                  div_done;
    logic [31:0]           div_quot;
    logic                  div_ovf;

    logic [3:0]            tidx;
    logic                  first;
    logic                  last;
    logic                  neg;
    logic signed [SUMW-1:0] p56;
    logic signed [SUMW-1:0] sum_next;
    logic signed [SUMW-1:0] sh14;
    logic [16:0]           qsat;
    logic [32:0]           tsat;
    logic signed [SUMW-1:0] ts_sum;
    logic [32:0]           tssat;
    logic signed [SUMW-1:0] ti_val;
    logic [32:0]           tisat;
    logic                  ss_ovf;
    logic                  act_err;

    logic signed [QW-1:0]  cq [4];
    logic                  conj_err;
    logic signed [QW-1:0]  fq [4];
    logic                  flip_err;
    logic signed [33:0]    e [10];
    logic signed [33:0]    mfull [9];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_q[0]  = s_tdata[15:0];
        in_q[1]  = s_tdata[31:16];
        in_q[2]  = s_tdata[47:32];
        in_q[3]  = s_tdata[63:48];
        in_t[0]  = s_tdata[95:64];
        in_t[1]  = s_tdata[127:96];
        in_t[2]  = s_tdata[159:128];
        in_scale = s_tdata[191:160];
    end

    // operand selection for the shared multiplier
    assign iidx = cnt_reg[3:0];

    always_comb
    begin
        op_a        = '0;
        op_b        = '0;
        issue       = '0;
        issue.idx   = iidx;
        unique case (state_reg)
            S_QP:
            begin
                issue.kind = K_QP;
                if (cnt_reg < N_QP)
                begin
                    issue.valid = 1'b1;
                    op_a = MOPW'(acc_q_reg[QP_A[iidx[1:0]]]);
                    op_b = MOPW'(bq_reg[QP_B[iidx]]);
                end
            end
            S_PP:
            begin
                issue.kind = K_PP;
                if (cnt_reg < N_PP)
                begin
                    issue.valid = 1'b1;
                    op_a = MOPW'(rq_reg[PP_A[iidx]]);
                    op_b = MOPW'(rq_reg[PP_B[iidx]]);
                end
            end
            S_ROT:
            begin
                issue.kind = K_ROT;
                if (cnt_reg < N_ROT)
                begin
                    issue.valid = 1'b1;
                    op_a = MOPW'(m_reg[iidx]);
                    op_b = MOPW'(vv_reg[ROT_COL[iidx]]);
                end
            end
            S_TS:
            begin
                issue.kind = K_TS;
                if (cnt_reg < N_TS)
                begin
                    issue.valid = 1'b1;
                    op_a = MOPW'(rt_reg[iidx[1:0]]);
                    op_b = {1'b0, acc_s_reg};
                end
            end
            S_SS:
            begin
                issue.kind = K_SS;
                if (cnt_reg < N_SS)
                begin
                    issue.valid = 1'b1;
                    op_a = {1'b0, acc_s_reg};
                    op_b = {1'b0, bs_reg};
                end
            end
            S_TI:
            begin
                issue.kind = K_TI;
                if (cnt_reg < N_TI)
                begin
                    issue.valid = 1'b1;
                    op_a = MOPW'(acc_t_reg[iidx[1:0]]);
                    op_b = {1'b0, inv_reg};
                end
            end
            default:
            begin
                issue.kind = K_QP;
            end
        endcase
    end

    scp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .a      (op_a),
        .b      (op_b),
        .tag_in (issue),
        .prod   (prod),
        .tag    (tag)
    );

    assign div_start = (state_reg == S_DIVST);

    scp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (acc_s_reg),
        .done    (div_done),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    // product handling
    assign tidx = tag.idx;

    always_comb
    begin
        if (tag.kind == K_QP)
        begin
            first = (tidx[1:0] == 2'd0);
            last  = (tidx[1:0] == 2'd3);
            neg   = QP_NEG[tidx];
        end
        else
        begin
            first = (ROT_COL[tidx] == 2'd0);
            last  = (ROT_COL[tidx] == 2'd2);
            neg   = 1'b0;
        end
        p56      = prod[SUMW-1:0];
        sum_next = (first ? SUMW'(0) : sum_reg) + (neg ? -p56 : p56);
        sh14     = sum_next >>> 14;
        qsat     = sat_q(sh14);
        tsat     = sat_t(sh14);
        ts_sum   = SUMW'(prod >>> 24) + SUMW'(acc_t_reg[tidx[1:0]]);
        tssat    = sat_t(ts_sum);
        ti_val   = -SUMW'(prod >>> 24);
        tisat    = sat_t(ti_val);
        ss_ovf   = |prod[63:56];
        act_err  = 1'b0;
        if (tag.valid)
        begin
            unique case (tag.kind)
                K_QP:    act_err = last && qsat[16];
                K_ROT:   act_err = last && tsat[32];
                K_TS:    act_err = tssat[32];
                K_SS:    act_err = ss_ovf;
                K_TI:    act_err = tisat[32];
                default: act_err = 1'b0;
            endcase
        end
    end

    // conjugate, final sign flip and rotation matrix
    always_comb
    begin
        conj_err = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (acc_q_reg[i] == -16'sd32768)
            begin
                cq[i]    = 16'sd32767;
                conj_err = 1'b1;
            end
            else
            begin
                cq[i] = -acc_q_reg[i];
            end
        end
        cq[3] = acc_q_reg[3];

        flip_err = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            fq[i] = rq_reg[i];
            if (rq_reg[3] < 0)
            begin
                if (rq_reg[i] == -16'sd32768)
                begin
                    fq[i]    = 16'sd32767;
                    flip_err = 1'b1;
                end
                else
                begin
                    fq[i] = -rq_reg[i];
                end
            end
        end

        for (int i = 0; i < 10; i++)
        begin
            e[i] = 34'(pp_reg[i]);
        end
        mfull[0] = e[3] + e[0] - e[1] - e[2];
        mfull[1] = (e[4] - e[9]) <<< 1;
        mfull[2] = (e[5] + e[8]) <<< 1;
        mfull[3] = (e[4] + e[9]) <<< 1;
        mfull[4] = e[3] - e[0] + e[1] - e[2];
        mfull[5] = (e[6] - e[7]) <<< 1;
        mfull[6] = (e[5] - e[8]) <<< 1;
        mfull[7] = (e[6] + e[7]) <<< 1;
        mfull[8] = e[3] - e[0] - e[1] + e[2];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                bq_reg[i] <= in_q[i];
                rq_reg[i] <= acc_q_reg[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                vv_reg[i] <= in_t[i];
            end
            bs_reg <= in_scale;
        end
        if (state_reg == S_DIVW && div_done)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rq_reg[i] <= cq[i];
            end
            inv_reg <= div_quot;
        end
        if (state_reg == S_MAT)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= mfull[i][33:14];
            end
        end
        if (tag.valid)
        begin
            unique case (tag.kind)
                K_QP:
                begin
                    sum_reg <= sum_next;
                    if (last)
                    begin
                        nq_reg[tidx[3:2]] <= qsat[15:0];
                    end
                end
                K_PP:
                begin
                    pp_reg[tidx] <= prod[31:0];
                end
                K_ROT:
                begin
                    sum_reg <= sum_next;
                    if (last)
                    begin
                        rt_reg[ROT_ROW[tidx]] <= tsat[31:0];
                    end
                end
                K_TS:
                begin
                    nt_reg[tidx[1:0]] <= tssat[31:0];
                end
                K_SS:
                begin
                    ns_reg <= ss_ovf ? 32'hFFFF_FFFF : prod[55:24];
                end
                K_TI:
                begin
                    vv_reg[tidx[1:0]] <= tisat[31:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer, accumulator and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            op_reg       <= OP_READ;
            err_reg      <= 1'b0;
            code_reg     <= ERR_OK;
            acc_q_reg[0] <= '0;
            acc_q_reg[1] <= '0;
            acc_q_reg[2] <= '0;
            acc_q_reg[3] <= 16'sd16384;
            acc_t_reg[0] <= '0;
            acc_t_reg[1] <= '0;
            acc_t_reg[2] <= '0;
            acc_s_reg    <= 32'd16777216;
            m_tvalid_reg <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= ERR_OK;
        end
        else
        begin
            err_reg <= err_reg | act_err;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        op_reg   <= s_tuser;
                        err_reg  <= 1'b0;
                        code_reg <= ERR_OK;
                        unique case (s_tuser)
                            OP_LOAD:
                            begin
                                for (int i = 0; i < 4; i++)
                                begin
                                    acc_q_reg[i] <= in_q[i];
                                end
                                for (int i = 0; i < 3; i++)
                                begin
                                    acc_t_reg[i] <= in_t[i];
                                end
                                acc_s_reg <= in_scale;
                                state_reg <= S_DONE;
                            end
                            OP_COMPOSE:
                            begin
                                state_reg <= S_QP;
                            end
                            OP_INVERT:
                            begin
                                if (acc_s_reg == '0)
                                begin
                                    code_reg  <= ERR_ZERO;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_DIVST;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_QP:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == N_QP)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_PP;
                    end
                end
                S_PP:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == N_PP)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MAT;
                    end
                end
                S_MAT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == N_ROT)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (op_reg == OP_COMPOSE) ? S_TS : S_FIN;
                    end
                end
                S_TS:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == N_TS)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SS;
                    end
                end
                S_SS:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == N_SS)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                end
                S_DIVST:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    cnt_reg <= '0;
                    if (div_done)
                    begin
                        err_reg   <= err_reg | div_ovf | conj_err;
                        state_reg <= S_TI;
                    end
                end
                S_TI:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == N_TI)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_PP;
                    end
                end
                S_FIN:
                begin
                    if (op_reg == OP_COMPOSE)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            acc_q_reg[i] <= nq_reg[i];
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_t_reg[i] <= nt_reg[i];
                        end
                        acc_s_reg <= ns_reg;
                        code_reg  <= err_reg ? ERR_SAT : ERR_OK;
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            acc_q_reg[i] <= fq[i];
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_t_reg[i] <= rt_reg[i];
                        end
                        acc_s_reg <= inv_reg;
                        code_reg  <= (err_reg || flip_err) ? ERR_SAT : ERR_OK;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_data_reg <= {acc_s_reg, acc_t_reg[2], acc_t_reg[1],
                                         acc_t_reg[0], acc_q_reg[3], acc_q_reg[2],
                                         acc_q_reg[1], acc_q_reg[0]};
                        out_user_reg <= code_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

// File: rtl/scp_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scp_chk: port checker for the similarity pose chain
// Watches the request and response channels and flags misbehaviour.
// ----------------------------------------------------------------------------
module scp_chk
    import scp_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [191:0] s_tdata,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [191:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // hold a stalled response
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled response changed");

    // hold a waiting request
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting request changed");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ERR_OK || m_tuser == ERR_SAT || m_tuser == ERR_ZERO))
        else $error("undefined error code");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind similarity_pose_chain scp_chk u_scp_chk (.*);
`default_nettype wire

// File: verif/similarity_pose_chain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// similarity_pose_chain_tb: pose accumulator check
// Drives load, compose, invert and read requests with random gaps on both
// channels and predicts every response from a fixed-point model of the
// accumulated similarity transform.
// ----------------------------------------------------------------------------
module similarity_pose_chain_tb;
    import scp_pkg::*;

    typedef struct {
        logic [15:0] q [4];
        logic [31:0] t [3];
        logic [31:0] s;
        logic [1:0]  err;
    } pose_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;

    longint acc_q [4];
    longint acc_t [3];
    longint acc_s;
    pose_t  pose_q [$];
    int     fails;
    bit     idle_on;
    bit     hold_rx;
    longint cycles;

    similarity_pose_chain i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, ref bit e);
        if (v < lo)
        begin
            e = 1;
            return lo;
        end
        if (v > hi)
        begin
            e = 1;
            return hi;
        end
        return v;
    endfunction

    function automatic void rotate_vec(longint q [4], longint v [3], ref longint r [3],
                                       ref bit e);
        longint x, y, z, w, s;
        longint m [9];
        x = q[0]; y = q[1]; z = q[2]; w = q[3];
        m[0] = w*w + x*x - y*y - z*z;
        m[1] = 2*(x*y - w*z);
        m[2] = 2*(x*z + w*y);
        m[3] = 2*(x*y + w*z);
        m[4] = w*w - x*x + y*y - z*z;
        m[5] = 2*(y*z - w*x);
        m[6] = 2*(x*z - w*y);
        m[7] = 2*(y*z + w*x);
        m[8] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 9; i++)
            m[i] = fshift(m[i], 14);
        for (int i = 0; i < 3; i++)
        begin
            s = m[3*i]*v[0] + m[3*i+1]*v[1] + m[3*i+2]*v[2];
            r[i] = clamp(fshift(s, 14), -64'sd2147483648, 64'sd2147483647, e);
        end
    endfunction

    function automatic void predict_pose(logic [1:0] op, logic [191:0] d);
        longint b [4];
        longint tb [3];
        longint nq [4];
        longint rt [3];
        longint m [3];
        longint sb, inv;
        longint ax, ay, az, aw;
        bit e;
        pose_t p;
        logic [1:0] code;
        e = 0;
        code = ERR_OK;
        for (int i = 0; i < 4; i++)
            b[i] = longint'($signed(d[16*i +: 16]));
        for (int i = 0; i < 3; i++)
            tb[i] = longint'($signed(d[64 + 32*i +: 32]));
        sb = longint'({32'd0, d[160 +: 32]});
        if (op == OP_LOAD)
        begin
            acc_q = b;
            acc_t = tb;
            acc_s = sb;
        end
        else if (op == OP_COMPOSE)
        begin
            ax = acc_q[0]; ay = acc_q[1]; az = acc_q[2]; aw = acc_q[3];
            nq[0] = clamp(fshift(aw*b[0] + ax*b[3] + ay*b[2] - az*b[1], 14), -32768, 32767, e);
            nq[1] = clamp(fshift(aw*b[1] - ax*b[2] + ay*b[3] + az*b[0], 14), -32768, 32767, e);
            nq[2] = clamp(fshift(aw*b[2] + ax*b[1] - ay*b[0] + az*b[3], 14), -32768, 32767, e);
            nq[3] = clamp(fshift(aw*b[3] - ax*b[0] - ay*b[1] - az*b[2], 14), -32768, 32767, e);
            rotate_vec(acc_q, tb, rt, e);
            for (int i = 0; i < 3; i++)
                acc_t[i] = clamp(fshift(rt[i]*acc_s, 24) + acc_t[i],
                                 -64'sd2147483648, 64'sd2147483647, e);
            acc_s = clamp(longint'(64'(acc_s * sb) >> 24), 0, 64'hFFFF_FFFF, e);
            acc_q = nq;
        end
        else if (op == OP_INVERT)
        begin
            if (acc_s == 0)
                code = ERR_ZERO;
            else
            begin
                inv = clamp(longint'((64'd1 << 48) / 64'(acc_s)), 0, 64'hFFFF_FFFF, e);
                for (int i = 0; i < 3; i++)
                    nq[i] = clamp(-acc_q[i], -32768, 32767, e);
                nq[3] = acc_q[3];
                for (int i = 0; i < 3; i++)
                    m[i] = clamp(-fshift(acc_t[i]*inv, 24),
                                 -64'sd2147483648, 64'sd2147483647, e);
                rotate_vec(nq, m, acc_t, e);
                if (nq[3] < 0)
                    for (int i = 0; i < 4; i++)
                        nq[i] = clamp(-nq[i], -32768, 32767, e);
                acc_q = nq;
                acc_s = inv;
            end
        end
        if (code == ERR_OK && e)
            code = ERR_SAT;
        for (int i = 0; i < 4; i++)
            p.q[i] = acc_q[i][15:0];
        for (int i = 0; i < 3; i++)
            p.t[i] = acc_t[i][31:0];
        p.s = acc_s[31:0];
        p.err = code;
        pose_q.push_back(p);
    endfunction

    // drop valid during a gap, else offer the next request straight away
    task automatic send_request(logic [1:0] op, logic [191:0] d);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pose(op, d);
        @(negedge clk);
    endtask

    function automatic logic [191:0] pack_pose(logic [15:0] q [4], logic [31:0] t [3],
                                               logic [31:0] s);
        return {s, t[2], t[1], t[0], q[3], q[2], q[1], q[0]};
    endfunction

    function automatic logic [191:0] rand_data();
        logic [191:0] d;
        for (int i = 0; i < 6; i++)
            d[32*i +: 32] = $urandom;
        return d;
    endfunction

    // quaternion with w in [8000, 16384] and x, y, z within +-8000, modest translation, scale near one
    function automatic logic [191:0] sane_data();
        logic [15:0] q [4];
        logic [31:0] t [3];
        for (int i = 0; i < 3; i++)
            q[i] = 16'($signed($urandom_range(0, 16000)) - 8000);
        q[3] = 16'($urandom_range(8000, 16384));
        for (int i = 0; i < 3; i++)
            t[i] = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        return pack_pose(q, t, $urandom_range(32'h0080_0000, 32'h0200_0000));
    endfunction

    task automatic test_directed();
        logic [15:0] q [4];
        logic [31:0] t [3];
        send_request(OP_READ, '0);
        send_request(OP_INVERT, '0);
        q = '{16'h7FFF, 16'h8000, 16'h0000, 16'h8000};
        t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        send_request(OP_LOAD, pack_pose(q, t, 32'hFFFF_FFFF));
        send_request(OP_COMPOSE, pack_pose(q, t, 32'hFFFF_FFFF));
        send_request(OP_INVERT, '0);
        send_request(OP_LOAD, pack_pose(q, t, 32'd0));
        send_request(OP_INVERT, '0);
        send_request(OP_READ, '1);
        send_request(OP_LOAD, pack_pose(q, t, 32'd1));
        send_request(OP_INVERT, '0);
        q = '{16'h0000, 16'h0000, 16'h0000, 16'hC000};
        send_request(OP_LOAD, pack_pose(q, t, 32'h0100_0000));
        send_request(OP_INVERT, '0);
        send_request(OP_COMPOSE, '1);
        send_request(OP_LOAD, '1);
        send_request(OP_COMPOSE, '1);
        send_request(OP_INVERT, '0);
        send_request(OP_COMPOSE, sane_data());
        send_request(OP_INVERT, '0);
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 19);
            if (r < 2)
                send_request(OP_LOAD, rand_data());
            else if (r < 4)
                send_request(OP_LOAD, sane_data());
            else if (r < 12)
                send_request(OP_COMPOSE, r < 11 ? sane_data() : rand_data());
            else if (r < 17)
                send_request(OP_INVERT, rand_data());
            else
                send_request(OP_READ, rand_data());
        end
    endtask

    task automatic test_backpressure();
        hold_rx = 1;
        for (int k = 0; k < 6; k++)
            send_request(k == 0 ? OP_LOAD : OP_COMPOSE, sane_data());
        hold_rx = 0;
    endtask

    always @(posedge clk)
    begin
        pose_t p;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pose_q.size() == 0)
            begin
                $error("unexpected response");
                fails++;
            end
            else
            begin
                p = pose_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[16*i +: 16] !== p.q[i])
                    begin
                        $error("out_q[%0d] expected %h actual %h", i, p.q[i],
                               m_tdata[16*i +: 16]);
                        fails++;
                    end
                for (int i = 0; i < 3; i++)
                    if (m_tdata[64 + 32*i +: 32] !== p.t[i])
                    begin
                        $error("out_t[%0d] expected %h actual %h", i, p.t[i],
                               m_tdata[64 + 32*i +: 32]);
                        fails++;
                    end
                if (m_tdata[160 +: 32] !== p.s)
                begin
                    $error("out_scale expected %h actual %h", p.s, m_tdata[160 +: 32]);
                    fails++;
                end
                if (m_tuser !== p.err)
                begin
                    $error("error expected %0d actual %0d", p.err, m_tuser);
                    fails++;
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                gap = 0;
                while (gap < 600)
                begin
                    @(negedge clk);
                    gap++;
                end
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int w;
        fails = 0;
        cycles = 0;
        idle_on = 1;
        hold_rx = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_READ;
        acc_q = '{0, 0, 0, 16384};
        acc_t = '{0, 0, 0};
        acc_s = 64'd16777216;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(380);
        idle_on = 0;
        test_random(60);
        s_tvalid <= 1'b0;
        w = 0;
        while (pose_q.size() != 0 && w < 5000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (100) @(posedge clk);
        if (fails == 0 && pose_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
